// File: rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, types and helper functions of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	// Fixed field widths.
	localparam int WORD_BITS  = 64;
	localparam int BIT_W      = 6;
	localparam int PAGE_W     = 36;
	localparam int CNT_W      = 16;
	localparam int PIDX_W     = 15;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 36;

	// Default number of pages the bitmap can track.
	localparam int MAX_PAGES_DEF = 32768;

	// Pages below 1 MiB with 4 KiB pages are never handed out.
	localparam logic [PAGE_W-1:0] LOW_MEM_PAGE   = 36'd256;
	localparam logic [PAGE_W-1:0] BASE_RESET_VAL = 36'd256;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOMEM = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KFIRST = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEND  = 2'd3;

	// Operation codes.
	localparam logic OP_FREE  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                latch_in;
		logic                addr_clr;
		logic                addr_inc;
		logic                addr_word;
		logic                wr_clear;
		logic                wr_free;
		logic                wr_alloc;
		logic                latch_idx;
		logic                load_page;
		logic                res_load;
		logic                res_grant;
		logic [STATUS_W-1:0] res_code;
		logic                out_load;
	} bpa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic op;
		logic pidx_oor;
		logic cnt_zero;
		logic word_nz;
		logic hit_in_range;
		logic next_in_range;
		logic guarded;
		logic last_word;
		logic out_busy;
	} bpa_stat_t;

	// Position of the lowest set bit of a word; zero for an empty word.
	function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] w);
		logic [WORD_BITS-1:0] onehot;
		logic [BIT_W-1:0]     pos;
		onehot = w & (~w + 64'd1);
		pos = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (onehot[b]) begin
				pos = pos | BIT_W'(b);
			end
		end
		return pos;
	endfunction

endpackage

// File: rtl/core/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Controller state machine: clearing pass, mark-free, and the allocate scan.
// ----------------------------------------------------------------------------
module bpa_ctrl
	import bpa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  bpa_stat_t stat,
	output bpa_cmd_t  cmd
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DEC   = 4'd2;
	localparam logic [3:0] S_MF_RD = 4'd3;
	localparam logic [3:0] S_MF_WR = 4'd4;
	localparam logic [3:0] S_A_RD  = 4'd5;
	localparam logic [3:0] S_A_CHK = 4'd6;
	localparam logic [3:0] S_A_CLR = 4'd7;
	localparam logic [3:0] S_A_GRD = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.wr_clear = 1'b1;
				cmd.addr_inc = 1'b1;
				if (stat.last_word) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DEC;
				end
			end
			S_DEC: begin
				if (stat.op == OP_FREE) begin
					if (stat.pidx_oor) begin
						cmd.res_load = 1'b1;
						cmd.res_code = ST_RANGE;
						state_d      = S_DONE;
					end else begin
						cmd.addr_word = 1'b1;
						state_d       = S_MF_RD;
					end
				end else if (stat.cnt_zero) begin
					cmd.res_load = 1'b1;
					cmd.res_code = ST_NOMEM;
					state_d      = S_DONE;
				end else begin
					cmd.addr_clr = 1'b1;
					state_d      = S_A_RD;
				end
			end
			S_MF_RD: begin
				state_d = S_MF_WR;
			end
			S_MF_WR: begin
				cmd.wr_free  = 1'b1;
				cmd.res_load = 1'b1;
				cmd.res_code = ST_OK;
				state_d      = S_DONE;
			end
			S_A_RD: begin
				state_d = S_A_CHK;
			end
			S_A_CHK: begin
				if (stat.word_nz) begin
					if (stat.hit_in_range) begin
						cmd.latch_idx = 1'b1;
						state_d       = S_A_CLR;
					end else begin
						cmd.res_load = 1'b1;
						cmd.res_code = ST_NOMEM;
						state_d      = S_DONE;
					end
				end else if (stat.next_in_range) begin
					cmd.addr_inc = 1'b1;
					state_d      = S_A_RD;
				end else begin
					cmd.res_load = 1'b1;
					cmd.res_code = ST_NOMEM;
					state_d      = S_DONE;
				end
			end
			S_A_CLR: begin
				cmd.wr_alloc  = 1'b1;
				cmd.load_page = 1'b1;
				state_d       = S_A_GRD;
			end
			S_A_GRD: begin
				// A guarded page stays consumed; rescan the same word.
				if (stat.guarded) begin
					state_d = S_A_RD;
				end else begin
					cmd.res_load  = 1'b1;
					cmd.res_grant = 1'b1;
					cmd.res_code  = ST_OK;
					state_d       = S_DONE;
				end
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/core/bpa_dp.sv
// ----------------------------------------------------------------------------
// bpa_dp
// Datapath: configuration registers, bitmap memory, bit search, page
// arithmetic, guard checks and the output register.
// ----------------------------------------------------------------------------
module bpa_dp
	import bpa_pkg::*;
#(
	parameter int MAX_PAGES = MAX_PAGES_DEF
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_op,
	input  logic [PIDX_W-1:0]     in_pidx,
	input  bpa_cmd_t              cmd,
	output bpa_stat_t             stat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STATUS_W-1:0]   out_status,
	output logic [PIDX_W-1:0]     out_index,
	output logic [PAGE_W-1:0]     out_page
);

	localparam int DEPTH_WORDS = MAX_PAGES / WORD_BITS;
	localparam int IW          = $clog2(MAX_PAGES);
	localparam int AW          = (IW > BIT_W) ? (IW - BIT_W) : 1;
	localparam int EW          = $clog2(MAX_PAGES + 1);

	// Configuration registers.
	logic [PAGE_W-1:0] base_q;
	logic [CNT_W-1:0]  count_q;
	logic [PAGE_W-1:0] kfirst_q;
	logic [PAGE_W-1:0] kend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= BASE_RESET_VAL;
			count_q  <= '0;
			kfirst_q <= '0;
			kend_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE:   base_q   <= cfg_data;
				REG_COUNT:  count_q  <= cfg_data[CNT_W-1:0];
				REG_KFIRST: kfirst_q <= cfg_data;
				REG_KEND:   kend_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	// The page count saturates at the bitmap capacity.
	logic [EW-1:0] eff;
	assign eff = (32'(count_q) > 32'(MAX_PAGES)) ? EW'(MAX_PAGES) : EW'(count_q);

	// Latched input item.
	logic              op_q;
	logic [PIDX_W-1:0] pidx_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q   <= in_op;
			pidx_q <= in_pidx;
		end
	end

	logic [IW-1:0] pidx_ext;
	assign pidx_ext = IW'(pidx_q);

	// Word address counter; it also drives the clearing pass after reset.
	logic [AW-1:0] addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.addr_clr) begin
			addr_q <= '0;
		end else if (cmd.addr_word) begin
			addr_q <= AW'(pidx_ext >> BIT_W);
		end else if (cmd.addr_inc) begin
			addr_q <= addr_q + AW'(1);
		end
	end

	// Bitmap memory with a registered read of the current word.
	logic [WORD_BITS-1:0] bitmap_q [DEPTH_WORDS];
	logic [WORD_BITS-1:0] rdata_q;
	logic [WORD_BITS-1:0] wdata;
	logic                 mem_we;
	logic [IW-1:0]        idx_q;

	always_comb begin
		mem_we = cmd.wr_clear | cmd.wr_free | cmd.wr_alloc;
		if (cmd.wr_free) begin
			wdata = rdata_q | (64'd1 << pidx_ext[BIT_W-1:0]);
		end else if (cmd.wr_alloc) begin
			wdata = rdata_q & ~(64'd1 << idx_q[BIT_W-1:0]);
		end else begin
			wdata = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bitmap_q[addr_q] <= wdata;
		end
		rdata_q <= bitmap_q[addr_q];
	end

	// Lowest free bit of the word just read.
	logic [BIT_W-1:0] low_bit;
	logic [IW-1:0]    hit_idx;
	assign low_bit = lowest_bit(rdata_q);
	assign hit_idx = IW'({addr_q, low_bit});

	always_ff @(posedge clk) begin
		if (cmd.latch_idx) begin
			idx_q <= hit_idx;
		end
	end

	// Physical page of the granted index, wrapping at 36 bits.
	logic [PAGE_W-1:0] page_q;

	always_ff @(posedge clk) begin
		if (cmd.load_page) begin
			page_q <= base_q + PAGE_W'(idx_q);
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.op            = op_q;
		stat.pidx_oor      = (32'(pidx_q) >= 32'(eff));
		stat.cnt_zero      = (eff == '0);
		stat.word_nz       = (rdata_q != '0);
		stat.hit_in_range  = (32'(hit_idx) < 32'(eff));
		stat.next_in_range = (((32'(addr_q) + 32'd1) << BIT_W) < 32'(eff));
		stat.guarded       = (page_q < LOW_MEM_PAGE) ||
		                     ((page_q >= kfirst_q) && (page_q < kend_q));
		stat.last_word     = (32'(addr_q) == 32'(DEPTH_WORDS - 1));
		stat.out_busy      = out_valid && !out_ready;
	end

	// Result of the current item.
	logic [STATUS_W-1:0] res_status_q;
	logic [PIDX_W-1:0]   res_index_q;
	logic [PAGE_W-1:0]   res_page_q;

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= cmd.res_code;
			res_index_q  <= cmd.res_grant ? PIDX_W'(idx_q) : '0;
			res_page_q   <= cmd.res_grant ? page_q : '0;
		end
	end

	// Output register; it holds a result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status <= res_status_q;
			out_index  <= res_index_q;
			out_page   <= res_page_q;
		end
	end

endmodule

// File: rtl/core/bitmap_page_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_top
// Physical page allocator over a free bitmap: mark-free and allocate items.
// ----------------------------------------------------------------------------
// Mark-free: an accepted item passes the decode, word read and word write states, then
// the done state. Allocate: the scan reads and checks the bitmap words in turn, and each
// guarded page it finds stays consumed while its word is reread.
// Items are handled one at a time, and a result not yet taken stalls the next one.
// Reset: after arst_n rises, a clearing pass writes MAX_PAGES/64 words (512 by
// default), one per cycle, before the first item is accepted.
module bitmap_page_allocator_top
	import bpa_pkg::*;
#(
	parameter int MAX_PAGES = MAX_PAGES_DEF
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,  // page_idx[14:0], zero pad[15]
	input  logic [0:0]            s_tuser,  // operation[0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [55:0]           m_tdata,  // granted_index[14:0], granted_page[50:15], pad
	output logic [1:0]            m_tuser   // status[1:0]
);

	bpa_cmd_t            cmd;
	bpa_stat_t           stat;
	logic [PIDX_W-1:0]   out_index;
	logic [PAGE_W-1:0]   out_page;

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bpa_dp #(
		.MAX_PAGES (MAX_PAGES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_op      (s_tuser[0]),
		.in_pidx    (s_tdata[PIDX_W-1:0]),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_index  (out_index),
		.out_page   (out_page)
	);

	assign m_tdata = {5'd0, out_page, out_index};

	// One item at a time: the input closes right after an item is taken.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in work");

	// Failed operations grant nothing.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
		else $error("failed result carries a grant");

	// A granted page never lies in low memory.
	a_low_mem: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_OK) && (m_tdata[50:15] != '0)
		|-> (m_tdata[50:15] >= LOW_MEM_PAGE))
		else $error("granted page below 1 MiB");

endmodule
